// ----- src/aes_round_transform_core_assert.svh -----
// Assertion macros for the AES round transform core
`ifndef AES_ROUND_TRANSFORM_CORE_ASSERT_SVH
`define AES_ROUND_TRANSFORM_CORE_ASSERT_SVH
// implication checked every clock, off while in reset
`define ART_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ART_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/art_pkg.sv -----
// Package: beat types, kind codes, AES S-box and xtime helper for the round transform
`timescale 1ns / 1ps
`default_nettype none
package art_pkg;

  typedef enum logic [1:0] {
    KIND_SUB   = 2'd0,
    KIND_SHIFT = 2'd1,
    KIND_MIX   = 2'd2,
    KIND_ROUND = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] state_hi;
    logic [63:0] state_lo;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_beat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt2(input logic [7:0] x);
    xt2 = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

// ----- src/aes_round_transform_core.sv -----
// From input beat to result valid, a beat passes the input register, then the result register.
// Throughput: one beat per cycle while out_ready is high; input register and result register each hold one beat.
// Input register feeds the transform logic, which feeds the result register.
// Reset: synchronous active-low rst_n clears both valid flags; no other state.
`timescale 1ns / 1ps
`default_nettype none
module aes_round_transform_core import art_pkg::*; (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output out_beat_t      out_data
);
  in_beat_t  in_r;
  logic      in_vld_r;
  out_beat_t res_nxt;
  out_beat_t res_r;
  logic      res_vld_r;
  logic      adv;

  art_datapath u_dp (.beat_i(in_r), .beat_o(res_nxt));

  assign adv       = in_vld_r && (!res_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (adv) res_vld_r <= 1'b1;
      else if (out_ready) res_vld_r <= 1'b0;
    end
    if (in_ready && in_valid) in_r <= in_data;
    if (adv) res_r <= res_nxt;
  end
endmodule
`default_nettype wire

// ----- src/art_datapath.sv -----
// Combinational SubBytes / ShiftRows / MixColumns selected by kind
`timescale 1ns / 1ps
`default_nettype none
module art_datapath import art_pkg::*; (
  input  wire in_beat_t  beat_i,
  output out_beat_t      beat_o
);
  logic [7:0] s0 [16];
  logic [7:0] s1 [16];
  logic [7:0] s2 [16];
  logic [7:0] s3 [16];
  logic do_sub, do_shift, do_mix;

  assign do_sub   = (beat_i.kind == KIND_SUB)   || (beat_i.kind == KIND_ROUND);
  assign do_shift = (beat_i.kind == KIND_SHIFT) || (beat_i.kind == KIND_ROUND);
  assign do_mix   = (beat_i.kind == KIND_MIX)   || (beat_i.kind == KIND_ROUND);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      s0[i]     = beat_i.state_lo[8*i +: 8];
      s0[i + 8] = beat_i.state_hi[8*i +: 8];
    end
    for (int i = 0; i < 16; i++) begin
      s1[i] = do_sub ? SBOX[s0[i]] : s0[i];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        s2[r*4 + c] = do_shift ? s1[r*4 + ((c + r) % 4)] : s1[r*4 + c];
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (do_mix) begin
        s3[c]      = xt2(s2[c]) ^ xt2(s2[c+4]) ^ s2[c+4] ^ s2[c+8] ^ s2[c+12];
        s3[c + 4]  = s2[c] ^ xt2(s2[c+4]) ^ xt2(s2[c+8]) ^ s2[c+8] ^ s2[c+12];
        s3[c + 8]  = s2[c] ^ s2[c+4] ^ xt2(s2[c+8]) ^ xt2(s2[c+12]) ^ s2[c+12];
        s3[c + 12] = xt2(s2[c]) ^ s2[c] ^ s2[c+4] ^ s2[c+8] ^ xt2(s2[c+12]);
      end else begin
        s3[c]      = s2[c];
        s3[c + 4]  = s2[c + 4];
        s3[c + 8]  = s2[c + 8];
        s3[c + 12] = s2[c + 12];
      end
    end
    for (int i = 0; i < 8; i++) begin
      beat_o.result_lo[8*i +: 8] = s3[i];
      beat_o.result_hi[8*i +: 8] = s3[i + 8];
    end
  end
endmodule
`default_nettype wire

// ----- src/art_checker.sv -----
// Port-level checker for the AES round transform core, with bind
`timescale 1ns / 1ps
`default_nettype none
`include "aes_round_transform_core_assert.svh"
module art_port_checker import art_pkg::*; (
  input wire            clk,
  input wire            rst_n,
  input wire            in_valid,
  input wire            in_ready,
  input wire            out_valid,
  input wire            out_ready,
  input wire out_beat_t out_data
);
  `ART_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `ART_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)
  `ART_ASSERT_NXT(a_stall_full, out_valid && !out_ready && !in_ready, !in_ready || out_ready)
  `ART_ASSERT_NXT(a_accept_leads, in_valid && in_ready && !out_valid, 1'b1 ##1 out_valid)
endmodule

bind aes_round_transform_core art_port_checker u_art_checker (.*);
`default_nettype wire

// ----- sim/art_checker.sv -----
// Checker: watches the AES round transform channels, predicts results and compares them
`timescale 1ns / 1ps
`default_nettype none
module art_checker import art_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire        [129:0] in_bits,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire        [127:0] out_bits,
  output int         fail_count,
  output int         pending
);

  out_beat_t expected_q[$];
  logic [7:0] sub_lut [256];

  // build the S-box from field inversion and the affine map
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] affine_of(input logic [7:0] x);
    logic [7:0] inv, base, r;
    inv = 8'h01;
    base = x;
    for (int e = 254; e != 0; e = e >> 1) begin
      if (e & 1) inv = gmul(inv, base);
      base = gmul(base, base);
    end
    r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
        ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    return r;
  endfunction

  initial for (int i = 0; i < 256; i++) sub_lut[i] = affine_of(i[7:0]);

  function automatic out_beat_t round_transform(input in_beat_t b);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    out_beat_t r;
    for (int i = 0; i < 8; i++) begin
      s[i] = b.state_lo[8*i +: 8];
      s[i+8] = b.state_hi[8*i +: 8];
    end
    if (b.kind == KIND_SUB || b.kind == KIND_ROUND)
      for (int i = 0; i < 16; i++) s[i] = sub_lut[s[i]];
    if (b.kind == KIND_SHIFT || b.kind == KIND_ROUND) begin
      for (int rr = 0; rr < 4; rr++)
        for (int c = 0; c < 4; c++) t[rr*4+c] = s[rr*4 + ((c+rr) & 3)];
      s = t;
    end
    if (b.kind == KIND_MIX || b.kind == KIND_ROUND)
      for (int c = 0; c < 4; c++) begin
        a0 = s[c]; a1 = s[c+4]; a2 = s[c+8]; a3 = s[c+12];
        s[c]    = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
        s[c+4]  = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
        s[c+8]  = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
        s[c+12] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
      end
    for (int i = 0; i < 8; i++) begin
      r.result_lo[8*i +: 8] = s[i];
      r.result_hi[8*i +: 8] = s[i+8];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_beat_t got, want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_beat_t'(out_bits);
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", got.result_lo, 64'h0);
        end else begin
          want = expected_q.pop_front();
          if (got.result_lo !== want.result_lo)
            report_mismatch("result_lo", got.result_lo, want.result_lo);
          if (got.result_hi !== want.result_hi)
            report_mismatch("result_hi", got.result_hi, want.result_hi);
        end
      end
      if (in_valid && in_ready) expected_q.push_back(round_transform(in_beat_t'(in_bits)));
      pending <= expected_q.size();
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench top: drives the AES round transform core and gives the verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_top import art_pkg::*;;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  in_beat_t in_data = '0;
  logic in_ready, out_valid;
  out_beat_t out_data;
  int fail_count, pending;
  int cycle_count = 0;
  int send_idle = 0, recv_stall = 0;

  always #4 clk = ~clk;

  aes_round_transform_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  art_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_bits(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_bits(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (recv_stall == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_beat(input kind_t k, input logic [63:0] lo, input logic [63:0] hi);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: k, state_hi: hi, state_lo: lo};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_pattern();
    case ($urandom_range(5))
      0: return 64'h0;
      1: return '1;
      2: return {8{8'(1 << $urandom_range(7))}};
      default: return rand64();
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < 4; k++) begin
      send_beat(kind_t'(k), 64'h0, 64'h0);
      send_beat(kind_t'(k), '1, '1);
      send_beat(kind_t'(k), 64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
      send_beat(kind_t'(k), 64'h8080808080808080, 64'h0101010101010101);
      send_beat(kind_t'(k), 64'h455313db0a0a8e8f, 64'hbcd6e14d5c220a01);
    end
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 85; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 85; end
        3: begin send_idle = 31; recv_stall = 31; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (int i = 0; i < 190; i++)
        send_beat(kind_t'($urandom_range(3)), rand_pattern(), rand_pattern());
      drain();
    end
    recv_stall = 0;
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
